### rtl/core/clns_pkg.sv
// shared types, codes and step table for the character lcd nibble sequencer
`default_nettype none

package clns_pkg;

    // request codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_INIT  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_POWER_UP_WAIT      = 3'd0;
    localparam logic [2:0] CFG_LONG_SETTLE_WAIT   = 3'd1;
    localparam logic [2:0] CFG_NIBBLE_SETTLE_WAIT = 3'd2;
    localparam logic [2:0] CFG_CLEAR_WAIT         = 3'd3;
    localparam logic [2:0] CFG_ENABLE_PULSE_WIDTH = 3'd4;
    localparam logic [2:0] CFG_MIRROR_PINS        = 3'd5;

    localparam int CfgDataW = 16;

    // reset values of the configuration registers
    localparam logic [15:0] RST_POWER_UP_WAIT      = 16'd30000;
    localparam logic [15:0] RST_LONG_SETTLE_WAIT   = 16'd4100;
    localparam logic [15:0] RST_NIBBLE_SETTLE_WAIT = 16'd100;
    localparam logic [15:0] RST_CLEAR_WAIT         = 16'd3000;
    localparam logic [7:0]  RST_ENABLE_PULSE_WIDTH = 8'd1;
    localparam logic        RST_MIRROR_PINS        = 1'b1;

    // step table layout
    localparam int PcW = 6;
    localparam logic [PcW-1:0] PC_WRITE = 6'd0;
    localparam logic [PcW-1:0] PC_INIT  = 6'd4;
    localparam logic [PcW-1:0] PC_CLEAR = 6'd34;

    typedef struct packed {
        logic [1:0] func;
        logic       register_select;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic        rs_level;
        logic [3:0]  port_bits;
        logic        enable_level;
        logic [15:0] wait_us;
        logic        last;
    } result_t;

    typedef enum logic [1:0] {
        NIB_CONST,
        NIB_HIGH,
        NIB_LOW
    } nib_src_t;

    typedef enum logic [2:0] {
        WAIT_POWER,
        WAIT_LONG,
        WAIT_SETTLE,
        WAIT_CLEAR,
        WAIT_PULSE
    } wait_sel_t;

    typedef struct packed {
        nib_src_t   src;
        logic [3:0] nib;
        logic       en;
        wait_sel_t  wsel;
        logic       last;
    } step_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic  load;
        logic  emit;
        step_t step;
    } dp_cmd_t;

    function automatic step_t mk_step(nib_src_t src, logic [3:0] nib, logic en,
                                      wait_sel_t wsel, logic last);
        step_t s;
        s.src  = src;
        s.nib  = nib;
        s.en   = en;
        s.wsel = wsel;
        s.last = last;
        return s;
    endfunction

    // enable-high half of a nibble
    function automatic step_t pulse(nib_src_t src, logic [3:0] nib);
        return mk_step(src, nib, 1'b1, WAIT_PULSE, 1'b0);
    endfunction

    // enable-low half of a nibble, also used for holds
    function automatic step_t low(nib_src_t src, logic [3:0] nib, wait_sel_t wsel,
                                  logic last);
        return mk_step(src, nib, 1'b0, wsel, last);
    endfunction

    // one entry per result; write at 0, init at 4, clear at 34
    function automatic step_t step_rom(logic [PcW-1:0] pc);
        step_t s;
        unique case (pc)
            // byte write
            6'd0:    s = pulse(NIB_HIGH, 4'h0);
            6'd1:    s = low(NIB_HIGH, 4'h0, WAIT_SETTLE, 1'b0);
            6'd2:    s = pulse(NIB_LOW, 4'h0);
            6'd3:    s = low(NIB_LOW, 4'h0, WAIT_SETTLE, 1'b1);
            // init: power-on hold
            6'd4:    s = low(NIB_CONST, 4'h0, WAIT_POWER, 1'b0);
            // function set nibbles
            6'd5:    s = pulse(NIB_CONST, 4'h3);
            6'd6:    s = low(NIB_CONST, 4'h3, WAIT_LONG, 1'b0);
            6'd7:    s = pulse(NIB_CONST, 4'h3);
            6'd8:    s = low(NIB_CONST, 4'h3, WAIT_SETTLE, 1'b0);
            6'd9:    s = pulse(NIB_CONST, 4'h3);
            6'd10:   s = low(NIB_CONST, 4'h3, WAIT_SETTLE, 1'b0);
            // switch to 4-bit mode
            6'd11:   s = pulse(NIB_CONST, 4'h2);
            6'd12:   s = low(NIB_CONST, 4'h2, WAIT_SETTLE, 1'b0);
            // 0x28 function set
            6'd13:   s = pulse(NIB_CONST, 4'h2);
            6'd14:   s = low(NIB_CONST, 4'h2, WAIT_SETTLE, 1'b0);
            6'd15:   s = pulse(NIB_CONST, 4'h8);
            6'd16:   s = low(NIB_CONST, 4'h8, WAIT_SETTLE, 1'b0);
            // 0x08 display off
            6'd17:   s = pulse(NIB_CONST, 4'h0);
            6'd18:   s = low(NIB_CONST, 4'h0, WAIT_SETTLE, 1'b0);
            6'd19:   s = pulse(NIB_CONST, 4'h8);
            6'd20:   s = low(NIB_CONST, 4'h8, WAIT_SETTLE, 1'b0);
            // 0x01 clear
            6'd21:   s = pulse(NIB_CONST, 4'h0);
            6'd22:   s = low(NIB_CONST, 4'h0, WAIT_SETTLE, 1'b0);
            6'd23:   s = pulse(NIB_CONST, 4'h1);
            6'd24:   s = low(NIB_CONST, 4'h1, WAIT_SETTLE, 1'b0);
            6'd25:   s = low(NIB_CONST, 4'h1, WAIT_CLEAR, 1'b0);
            // 0x06 entry mode
            6'd26:   s = pulse(NIB_CONST, 4'h0);
            6'd27:   s = low(NIB_CONST, 4'h0, WAIT_SETTLE, 1'b0);
            6'd28:   s = pulse(NIB_CONST, 4'h6);
            6'd29:   s = low(NIB_CONST, 4'h6, WAIT_SETTLE, 1'b0);
            // 0x0f display on
            6'd30:   s = pulse(NIB_CONST, 4'h0);
            6'd31:   s = low(NIB_CONST, 4'h0, WAIT_SETTLE, 1'b0);
            6'd32:   s = pulse(NIB_CONST, 4'hF);
            6'd33:   s = low(NIB_CONST, 4'hF, WAIT_SETTLE, 1'b1);
            // clear sequence: 0x06 entry mode and hold
            6'd34:   s = pulse(NIB_CONST, 4'h0);
            6'd35:   s = low(NIB_CONST, 4'h0, WAIT_SETTLE, 1'b0);
            6'd36:   s = pulse(NIB_CONST, 4'h6);
            6'd37:   s = low(NIB_CONST, 4'h6, WAIT_SETTLE, 1'b0);
            6'd38:   s = low(NIB_CONST, 4'h6, WAIT_SETTLE, 1'b0);
            // 0x0f display on
            6'd39:   s = pulse(NIB_CONST, 4'h0);
            6'd40:   s = low(NIB_CONST, 4'h0, WAIT_SETTLE, 1'b0);
            6'd41:   s = pulse(NIB_CONST, 4'hF);
            6'd42:   s = low(NIB_CONST, 4'hF, WAIT_SETTLE, 1'b0);
            // 0x01 clear and hold
            6'd43:   s = pulse(NIB_CONST, 4'h0);
            6'd44:   s = low(NIB_CONST, 4'h0, WAIT_SETTLE, 1'b0);
            6'd45:   s = pulse(NIB_CONST, 4'h1);
            6'd46:   s = low(NIB_CONST, 4'h1, WAIT_SETTLE, 1'b0);
            6'd47:   s = low(NIB_CONST, 4'h1, WAIT_CLEAR, 1'b1);
            default: s = low(NIB_CONST, 4'h0, WAIT_SETTLE, 1'b1);
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/core/clns_ctrl.sv
// controller: walks the step table for one request at a time
`default_nettype none

module clns_ctrl
    import clns_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic [1:0] func,
    output logic         busy,
    output dp_cmd_t      cmd
);

    ctrl_state_t state_reg, state_next;
    logic [PcW-1:0] pc_reg, pc_next;
    logic  accept;
    step_t cur_step;

    assign accept   = start && (state_reg == ST_IDLE);
    assign cur_step = step_rom(pc_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority case (func)
                        FUNC_WRITE:
                        begin
                            state_next = ST_RUN;
                            pc_next    = PC_WRITE;
                        end
                        FUNC_INIT:
                        begin
                            state_next = ST_RUN;
                            pc_next    = PC_INIT;
                        end
                        FUNC_CLEAR:
                        begin
                            state_next = ST_RUN;
                            pc_next    = PC_CLEAR;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RUN:
            begin
                if (cur_step.last)
                    state_next = ST_IDLE;
                else
                    pc_next = pc_reg + 1'b1;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.load = accept;
        cmd.emit = 1'b0;
        cmd.step = cur_step;
        busy     = 1'b0;
        unique case (state_reg)
            ST_IDLE: ;
            ST_RUN:
            begin
                cmd.emit = 1'b1;
                busy     = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/clns_dp.sv
// datapath: config registers, request capture and result register
`default_nettype none

module clns_dp
    import clns_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_wdata,
    input  wire logic                req_rs,
    input  wire logic [7:0]          req_data,
    input  wire dp_cmd_t             cmd,
    output logic                     result_valid,
    output result_t                  result
);

    logic [15:0] power_up_wait_reg;
    logic [15:0] long_settle_wait_reg;
    logic [15:0] nibble_settle_wait_reg;
    logic [15:0] clear_wait_reg;
    logic [7:0]  enable_pulse_width_reg;
    logic        mirror_pins_reg;

    logic        rs_reg;
    logic [7:0]  data_reg;
    logic        valid_reg;
    result_t     result_reg;

    logic [3:0]  nib;
    logic [3:0]  port;
    logic [15:0] wait_val;
    result_t     result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_up_wait_reg      <= RST_POWER_UP_WAIT;
            long_settle_wait_reg   <= RST_LONG_SETTLE_WAIT;
            nibble_settle_wait_reg <= RST_NIBBLE_SETTLE_WAIT;
            clear_wait_reg         <= RST_CLEAR_WAIT;
            enable_pulse_width_reg <= RST_ENABLE_PULSE_WIDTH;
            mirror_pins_reg        <= RST_MIRROR_PINS;
        end
        else if (cfg_we)
        begin
            priority case (cfg_index)
                CFG_POWER_UP_WAIT:      power_up_wait_reg      <= cfg_wdata;
                CFG_LONG_SETTLE_WAIT:   long_settle_wait_reg   <= cfg_wdata;
                CFG_NIBBLE_SETTLE_WAIT: nibble_settle_wait_reg <= cfg_wdata;
                CFG_CLEAR_WAIT:         clear_wait_reg         <= cfg_wdata;
                CFG_ENABLE_PULSE_WIDTH: enable_pulse_width_reg <= cfg_wdata[7:0];
                CFG_MIRROR_PINS:        mirror_pins_reg        <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rs_reg   <= req_rs;
            data_reg <= req_data;
        end
    end

    always_comb
    begin
        unique case (cmd.step.src)
            NIB_HIGH:  nib = data_reg[7:4];
            NIB_LOW:   nib = data_reg[3:0];
            NIB_CONST: nib = cmd.step.nib;
            default:   nib = cmd.step.nib;
        endcase

        port = mirror_pins_reg ? {nib[0], nib[1], nib[2], nib[3]} : nib;

        unique case (cmd.step.wsel)
            WAIT_POWER:  wait_val = power_up_wait_reg;
            WAIT_LONG:   wait_val = long_settle_wait_reg;
            WAIT_SETTLE: wait_val = nibble_settle_wait_reg;
            WAIT_CLEAR:  wait_val = clear_wait_reg;
            WAIT_PULSE:  wait_val = {8'd0, enable_pulse_width_reg};
            default:     wait_val = nibble_settle_wait_reg;
        endcase

        // only byte writes drive rs from the request
        result_next.rs_level     = (cmd.step.src == NIB_CONST) ? 1'b0 : rs_reg;
        result_next.port_bits    = port;
        result_next.enable_level = cmd.step.en;
        result_next.wait_us      = wait_val;
        result_next.last         = cmd.step.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

### rtl/core/char_lcd_nibble_sequencer_top.sv
// top level of the character lcd 4-bit nibble sequencer
`default_nettype none

// Turns each request into a list of pin states for a character LCD on a
// 4-bit bus: a byte write gives 4 results, init gives 30 and clear gives 14;
// func 3 gives none. A request is taken when start is high and busy is low.
// Results come out one per clock cycle, the first once the request has
// passed the controller state register and the result register, each shown
// for exactly one cycle with result_valid high; the receiver cannot stall,
// so it must take every result as it comes. busy stays high while the
// controller walks the request's entries (4, 30 or 14), one step table
// entry per cycle. A new request may be taken in the cycle the last result
// is shown. wait_us is a hold time for the downstream pin driver; the block
// itself does not wait it out. The user must write configuration registers
// through cfg_we/cfg_index/cfg_wdata only while busy is low; the block does
// not enforce this. An index past the list is ignored.
module char_lcd_nibble_sequencer_top
    import clns_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // request transfer
    input  wire logic                start,
    output logic                     busy,
    input  wire req_t                req,
    // result transfer
    output logic                     result_valid,
    output result_t                  result,
    // configuration writes
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_wdata
);

    dp_cmd_t cmd;

    // sequencing: state and step pointer
    clns_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (req.func),
        .busy  (busy),
        .cmd   (cmd)
    );

    // config, nibble select, mirroring and the result register
    clns_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .req_rs       (req.register_select),
        .req_data     (req.data_byte),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
